// File: rtl/core/kdt_pkg.sv
package kdt_pkg;

  // default table depth
  localparam int ENTRIES_DEF = 16;

  // field widths
  localparam int OP_W  = 3;
  localparam int KEY_W = 16;
  localparam int IVL_W = 32;
  localparam int NOW_W = 62;
  localparam int DL_W  = 63;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_TEST      = 3'd0,
    OP_SET       = 3'd1,
    OP_CLEAR     = 3'd2,
    OP_SWEEP     = 3'd3,
    OP_CLEAR_ALL = 3'd4
  } op_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;        // capture the input item, restart the scan
    logic scan_issue;  // read one slot of the key and deadline memories
    logic commit;      // apply the item and write the result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic needs_scan;  // op at the input needs a pass over the slots
    logic last_issue;  // the slot being read is the last one
    logic out_free;    // result register can take a new result
  } sts_t;

endpackage

// File: rtl/core/kdt_ctrl.sv
module kdt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  kdt_pkg::sts_t sts,
  output kdt_pkg::cmd_t cmd
);

  kdt_pkg::state_t state_r;
  kdt_pkg::state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kdt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    in_stall       = 1'b1;
    case (state_r)
      kdt_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (sts.needs_scan) begin
            state_nxt = kdt_pkg::ST_SCAN;
          end else begin
            state_nxt = kdt_pkg::ST_DONE;
          end
        end
      end
      kdt_pkg::ST_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (sts.last_issue) begin
          state_nxt = kdt_pkg::ST_DRAIN;
        end
      end
      kdt_pkg::ST_DRAIN: begin
        state_nxt = kdt_pkg::ST_DONE;
      end
      kdt_pkg::ST_DONE: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = kdt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = kdt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/core/kdt_dpath.sv
module kdt_dpath #(
  parameter int ENTRIES = kdt_pkg::ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [kdt_pkg::OP_W-1:0]    in_op,
  input  logic [kdt_pkg::KEY_W-1:0]   in_key_id,
  input  logic signed [kdt_pkg::IVL_W-1:0] in_interval_ms,
  input  logic [kdt_pkg::NOW_W-1:0]   in_now_ms,
  input  kdt_pkg::cmd_t               cmd,
  output kdt_pkg::sts_t               sts,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_passed,
  output logic                        out_table_full
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = IW + 1;

  // captured item
  logic [kdt_pkg::OP_W-1:0]  op_r;
  logic [kdt_pkg::KEY_W-1:0] key_r;
  logic [kdt_pkg::IVL_W-1:0] ivl_r;
  logic [kdt_pkg::NOW_W-1:0] now_r;

  // slot storage
  logic [ENTRIES-1:0]        valid_r;
  logic [ENTRIES-1:0]        valid_nxt;
  logic [kdt_pkg::KEY_W-1:0] key_mem [ENTRIES];
  logic [kdt_pkg::DL_W-1:0]  dl_mem  [ENTRIES];

  // scan counter and read stage
  logic [CW-1:0]             cnt_r;
  logic                      rd_v_r;
  logic [IW-1:0]             rd_idx_r;
  logic [kdt_pkg::KEY_W-1:0] rd_key_r;
  logic [kdt_pkg::DL_W-1:0]  rd_dl_r;

  // search results
  logic                      found_r;
  logic [IW-1:0]             found_idx_r;
  logic [kdt_pkg::DL_W-1:0]  found_dl_r;
  logic                      free_found_r;
  logic [IW-1:0]             free_idx_r;

  // result register
  logic                      out_valid_r;
  logic                      out_passed_r;
  logic                      out_full_r;
  logic                      passed_nxt;
  logic                      full_nxt;

  // memory write port
  logic                      wr_en;
  logic [IW-1:0]             wr_idx;

  logic                      ivl_pos;
  logic [kdt_pkg::DL_W-1:0]  now_ext;
  logic [kdt_pkg::DL_W-1:0]  dl_new;
  logic                      rd_hit;
  logic                      sweep_clr;

  assign ivl_pos = (ivl_r != '0) && !ivl_r[kdt_pkg::IVL_W-1];
  assign now_ext = {1'b0, now_r};
  assign dl_new  = now_ext + {{(kdt_pkg::DL_W-kdt_pkg::IVL_W+1){1'b0}},
                              ivl_r[kdt_pkg::IVL_W-2:0]};
  assign rd_hit  = rd_v_r && valid_r[rd_idx_r];
  assign sweep_clr = rd_hit && (op_r == kdt_pkg::OP_SWEEP) && (rd_dl_r <= now_ext);

  // status to the controller
  assign sts.needs_scan = (in_op == kdt_pkg::OP_TEST) || (in_op == kdt_pkg::OP_SET) ||
                          (in_op == kdt_pkg::OP_CLEAR) || (in_op == kdt_pkg::OP_SWEEP);
  assign sts.last_issue = (cnt_r == CW'(ENTRIES - 1));
  assign sts.out_free   = !out_valid_r || !out_stall;

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_op;
      key_r <= in_key_id;
      ivl_r <= in_interval_ms;
      now_r <= in_now_ms;
    end
  end

  // scan counter and read stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      rd_v_r <= 1'b0;
    end else begin
      rd_v_r <= cmd.scan_issue;
      if (cmd.load) begin
        cnt_r <= '0;
      end else if (cmd.scan_issue) begin
        cnt_r <= cnt_r + CW'(1);
      end
    end
  end

  // registered memory read, one slot per cycle
  always_ff @(posedge clk) begin
    if (cmd.scan_issue) begin
      rd_idx_r <= cnt_r[IW-1:0];
      rd_key_r <= key_mem[cnt_r[IW-1:0]];
      rd_dl_r  <= dl_mem[cnt_r[IW-1:0]];
    end
  end

  // memory write on commit
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_idx] <= key_r;
      dl_mem[wr_idx]  <= dl_new;
    end
  end

  // lowest matching slot and lowest free slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
    end else if (cmd.load) begin
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
    end else if (rd_v_r) begin
      if (rd_hit && (rd_key_r == key_r) && !found_r) begin
        found_r <= 1'b1;
      end
      if (!valid_r[rd_idx_r] && !free_found_r) begin
        free_found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_hit && (rd_key_r == key_r) && !found_r) begin
      found_idx_r <= rd_idx_r;
      found_dl_r  <= rd_dl_r;
    end
    if (rd_v_r && !valid_r[rd_idx_r] && !free_found_r) begin
      free_idx_r <= rd_idx_r;
    end
  end

  // valid bits, result and write port
  always_comb begin
    valid_nxt  = valid_r;
    passed_nxt = 1'b0;
    full_nxt   = 1'b0;
    wr_en      = 1'b0;
    wr_idx     = found_idx_r;
    if (sweep_clr) begin
      valid_nxt[rd_idx_r] = 1'b0;
    end
    if (cmd.commit) begin
      case (op_r)
        kdt_pkg::OP_TEST: begin
          if (found_r && (found_dl_r > now_ext)) begin
            passed_nxt = 1'b0;
          end else begin
            if (found_r) begin
              valid_nxt[found_idx_r] = 1'b0;
            end
            passed_nxt = 1'b1;
          end
        end
        kdt_pkg::OP_SET: begin
          if (ivl_pos) begin
            if (found_r) begin
              wr_en      = 1'b1;
              passed_nxt = 1'b1;
            end else if (free_found_r) begin
              wr_en              = 1'b1;
              wr_idx             = free_idx_r;
              valid_nxt[free_idx_r] = 1'b1;
              passed_nxt         = 1'b1;
            end else begin
              full_nxt = 1'b1;
            end
          end
        end
        kdt_pkg::OP_CLEAR: begin
          if (found_r) begin
            valid_nxt[found_idx_r] = 1'b0;
            passed_nxt             = 1'b1;
          end
        end
        kdt_pkg::OP_SWEEP: begin
          passed_nxt = 1'b1;
        end
        kdt_pkg::OP_CLEAR_ALL: begin
          valid_nxt  = '0;
          passed_nxt = 1'b1;
        end
        default: begin
          passed_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_passed_r <= passed_nxt;
      out_full_r   <= full_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_passed     = out_passed_r;
  assign out_table_full = out_full_r;

  // a commit never overwrites a result still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || !out_stall))
    else $error("result overwritten while stalled");

  // clear all leaves the table empty
  a_clear_all: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && (op_r == kdt_pkg::OP_CLEAR_ALL)) |=> (valid_r == '0))
    else $error("table not empty after clear all");

  // full and passed are never reported together
  a_full_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_passed_r && out_full_r))
    else $error("full and passed both set");

  // scan reads stay inside the table
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_issue |-> (cnt_r < CW'(ENTRIES)))
    else $error("scan beyond last slot");

  // a successful set leaves a valid slot behind
  a_set_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && (op_r == kdt_pkg::OP_SET) && passed_nxt) |=> (valid_r != '0))
    else $error("set passed without a valid slot");

endmodule

// File: rtl/core/keyed_deadline_table.sv
// sequence: test, set, clear and sweep scan every slot before the result is registered;
//   clear all and unused op codes skip the scan
// throughput: a new item is taken only once the last result is committed; the scan
//   reads one slot per cycle through the single read port of the key and deadline memories
// reset: synchronous active-low rst_n empties the table (valid bits cleared at once)
//   and drops any pending result; no clearing pass
module keyed_deadline_table #(
  parameter int ENTRIES = kdt_pkg::ENTRIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [kdt_pkg::OP_W-1:0]         in_op,
  input  logic [kdt_pkg::KEY_W-1:0]        in_key_id,
  input  logic signed [kdt_pkg::IVL_W-1:0] in_interval_ms,
  input  logic [kdt_pkg::NOW_W-1:0]        in_now_ms,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_passed,
  output logic                             out_table_full
);

  kdt_pkg::cmd_t cmd;
  kdt_pkg::sts_t sts;

  // sequencer
  kdt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // slot storage, search and result
  kdt_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_op          (in_op),
    .in_key_id      (in_key_id),
    .in_interval_ms (in_interval_ms),
    .in_now_ms      (in_now_ms),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_passed     (out_passed),
    .out_table_full (out_table_full)
  );

endmodule

// File: sim/keyed_deadline_table_tb.sv
module keyed_deadline_table_tb;
  import kdt_pkg::*;

  localparam int ENTRIES = ENTRIES_DEF;
  localparam int RANDOM_ITEMS = 1330;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int KEY_POOL = 20;

  // op codes the block ignores
  localparam logic [OP_W-1:0] OP_RSVD_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD_HI = 3'd7;

  typedef struct packed {
    logic passed;
    logic full;
  } deadline_result_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [OP_W-1:0] in_op;
  logic [KEY_W-1:0] in_key_id;
  logic signed [IVL_W-1:0] in_interval_ms;
  logic [NOW_W-1:0] in_now_ms;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_passed;
  logic out_table_full;

  // predicted table contents
  logic tbl_valid [ENTRIES];
  logic [KEY_W-1:0] tbl_key [ENTRIES];
  logic [DL_W-1:0] tbl_deadline [ENTRIES];

  deadline_result_t pending_results [$];
  int error_count = 0;
  int cycle_count = 0;
  int stall_run = 0;
  logic calm = 1'b0;

  keyed_deadline_table #(.ENTRIES(ENTRIES)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_op(in_op),
    .in_key_id(in_key_id),
    .in_interval_ms(in_interval_ms),
    .in_now_ms(in_now_ms),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_passed(out_passed),
    .out_table_full(out_table_full)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int find_key(logic [KEY_W-1:0] key);
    for (int i = 0; i < ENTRIES; i++) begin
      if (tbl_valid[i] && tbl_key[i] == key) return i;
    end
    return -1;
  endfunction

  // applies one item to the predicted table and returns its result
  function automatic deadline_result_t apply_deadline_op(
    logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
    logic signed [IVL_W-1:0] ivl, logic [NOW_W-1:0] now);
    deadline_result_t res;
    int slot;
    res = '0;
    case (op)
      OP_TEST: begin
        slot = find_key(key);
        if (slot >= 0 && tbl_deadline[slot] > now) begin
          res.passed = 1'b0;
        end else begin
          if (slot >= 0) tbl_valid[slot] = 1'b0;
          res.passed = 1'b1;
        end
      end
      OP_SET: begin
        if (ivl > 0) begin
          slot = find_key(key);
          // new id takes the lowest free slot
          if (slot < 0) begin
            for (int i = ENTRIES - 1; i >= 0; i--) begin
              if (!tbl_valid[i]) slot = i;
            end
          end
          if (slot < 0) begin
            res.full = 1'b1;
          end else begin
            tbl_valid[slot] = 1'b1;
            tbl_key[slot] = key;
            tbl_deadline[slot] = {{(DL_W-NOW_W){1'b0}}, now} +
                                 {{(DL_W-IVL_W){1'b0}}, ivl};
            res.passed = 1'b1;
          end
        end
      end
      OP_CLEAR: begin
        slot = find_key(key);
        if (slot >= 0) begin
          tbl_valid[slot] = 1'b0;
          res.passed = 1'b1;
        end
      end
      OP_SWEEP: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (tbl_valid[i] && tbl_deadline[i] <= now) tbl_valid[i] = 1'b0;
        end
        res.passed = 1'b1;
      end
      OP_CLEAR_ALL: begin
        for (int i = 0; i < ENTRIES; i++) tbl_valid[i] = 1'b0;
        res.passed = 1'b1;
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // present one item and record its expected result once accepted
  task automatic send_item(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                           input logic signed [IVL_W-1:0] ivl,
                           input logic [NOW_W-1:0] now);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_op = op;
    in_key_id = key;
    in_interval_ms = ivl;
    in_now_ms = now;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(apply_deadline_op(op, key, ivl, now));
  endtask

  // hold off the sender until every expected result is back
  task automatic wait_for_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // one of each op, the interval edges and the expiry boundary
  task automatic test_single_ops();
    send_item(OP_TEST, 16'h0000, 32'sd5, 62'd1000);
    send_item(OP_SET, 16'hFFFF, 32'sd0, 62'd1000);
    send_item(OP_SET, 16'hFFFF, 32'sh80000000, 62'd1000);
    send_item(OP_SET, 16'hFFFF, -32'sd1, 62'd1000);
    send_item(OP_SET, 16'hFFFF, 32'sh7FFFFFFF, {NOW_W{1'b1}});
    send_item(OP_TEST, 16'hFFFF, 32'sd0, {NOW_W{1'b1}});
    send_item(OP_SET, 16'h0000, 32'sd1, 62'd100);
    send_item(OP_TEST, 16'h0000, 32'sd0, 62'd100);
    // deadline equal to now counts as expired
    send_item(OP_TEST, 16'h0000, 32'sd0, 62'd101);
    send_item(OP_CLEAR, 16'h0000, 32'sd0, 62'd101);
    send_item(OP_SET, 16'h0005, 32'sd10, 62'd0);
    send_item(OP_CLEAR, 16'h0005, 32'sd0, 62'd0);
    send_item(OP_SET, 16'h0007, 32'sd5, 62'd0);
    send_item(OP_SWEEP, 16'h0000, 32'sd0, 62'd5);
    send_item(OP_TEST, 16'h0007, 32'sd0, 62'd0);
    send_item(OP_CLEAR_ALL, 16'h0000, 32'sd0, 62'd0);
    send_item(OP_TEST, 16'hFFFF, 32'sd0, 62'd0);
    for (int op = OP_RSVD_LO; op <= OP_RSVD_HI; op++) begin
      send_item(OP_W'(op), 16'h0000, 32'sd7, 62'd0);
    end
  endtask

  // fill every slot, overflow, then reuse freed slots
  task automatic test_table_full();
    calm = 1'b1;
    for (int i = 0; i < ENTRIES; i++) begin
      send_item(OP_SET, KEY_W'(16'h0100 + i), 32'sd1000, 62'd0);
    end
    send_item(OP_SET, 16'hBEEF, 32'sd50, 62'd0);
    send_item(OP_SET, 16'h010F, 32'sd5, 62'd0);
    send_item(OP_TEST, 16'h010F, 32'sd0, 62'd5);
    send_item(OP_SET, 16'hBEEF, 32'sd50, 62'd5);
    send_item(OP_SET, 16'hCAFE, 32'sd50, 62'd5);
    send_item(OP_SWEEP, 16'h0000, 32'sd0, 62'd1000);
    send_item(OP_SET, 16'hCAFE, 32'sd50, 62'd1000);
    send_item(OP_CLEAR_ALL, 16'h0000, 32'sd0, 62'd1000);
    calm = 1'b0;
  endtask

  // runs of ops on a small id pool with a slowly advancing clock
  task automatic test_random_traffic();
    logic [NOW_W-1:0] clock_ms;
    logic [KEY_W-1:0] key_mask;
    logic [KEY_W-1:0] key;
    logic signed [IVL_W-1:0] ivl;
    logic [OP_W-1:0] op;
    int r;
    int n;
    clock_ms = 62'd5000;
    key_mask = '0;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 150 == 0) begin
        calm = ($urandom_range(0, 3) == 0);
        key_mask = KEY_W'($urandom);
      end
      if (n % 400 == 399) wait_for_results();
      // time mostly creeps forward, rarely jumps anywhere
      if ($urandom_range(0, 99) < 2) clock_ms = NOW_W'({$urandom, $urandom});
      else clock_ms = clock_ms + NOW_W'($urandom_range(0, 12));
      if ($urandom_range(0, 9) == 0) key = KEY_W'($urandom);
      else key = key_mask ^ KEY_W'($urandom_range(0, KEY_POOL - 1));
      r = $urandom_range(0, 99);
      if (r < 55) ivl = $urandom_range(1, 60);
      else if (r < 75) ivl = $urandom_range(500, 5000);
      else if (r < 83) ivl = 0;
      else if (r < 90) ivl = -$urandom_range(1, 1000);
      else if (r < 96) ivl = IVL_W'($urandom);
      else ivl = 32'sh7FFFFFFF;
      r = $urandom_range(0, 99);
      if (r < 40) op = OP_SET;
      else if (r < 65) op = OP_TEST;
      else if (r < 80) op = OP_CLEAR;
      else if (r < 90) op = OP_SWEEP;
      else if (r < 93) op = OP_CLEAR_ALL;
      else if (r < 96) op = OP_W'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
      else op = OP_W'($urandom_range(OP_TEST, OP_CLEAR));
      send_item(op, key, ivl, clock_ms);
    end
    calm = 1'b0;
  endtask

  // receiver back-pressure
  always @(negedge clk) begin
    if (calm) begin
      out_stall = 1'b0;
    end else if (stall_run > 0) begin
      out_stall = 1'b1;
      stall_run--;
    end else begin
      out_stall = 1'b0;
      if ($urandom_range(0, 3) == 0) stall_run = pick_gap();
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin : check_results
    deadline_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with no item outstanding: passed %0b table_full %0b",
               out_passed, out_table_full);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_passed !== want.passed) begin
          $error("passed: expected %0b, got %0b", want.passed, out_passed);
          error_count++;
        end
        if (out_table_full !== want.full) begin
          $error("table_full: expected %0b, got %0b", want.full, out_table_full);
          error_count++;
        end
      end
    end
  end

  // run time guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("keyed_deadline_table_tb: errors");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = OP_TEST;
    in_key_id = '0;
    in_interval_ms = '0;
    in_now_ms = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_key[i] = '0;
      tbl_deadline[i] = '0;
    end
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    test_single_ops();
    test_table_full();
    test_random_traffic();

    wait_for_results();
    repeat (ENTRIES + 8) @(posedge clk);
    if (error_count == 0) begin
      $display("keyed_deadline_table_tb: clean");
    end else begin
      $display("keyed_deadline_table_tb: errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/kdt_pkg.sv
rtl/core/kdt_ctrl.sv
rtl/core/kdt_dpath.sv
rtl/core/keyed_deadline_table.sv
sim/keyed_deadline_table_tb.sv
